/* rtl/radial_cosine_image_blend_core_assert.svh */
// ---------------------------------------------------------------------------
// radial cosine image blend assertion macros
// shorthand for the concurrent checks of the blend core
// ---------------------------------------------------------------------------
`ifndef RADIAL_COSINE_IMAGE_BLEND_CORE_ASSERT_SVH
`define RADIAL_COSINE_IMAGE_BLEND_CORE_ASSERT_SVH

// same-cycle implication
`define RCIB_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rcib check failed");

// next-cycle implication
`define RCIB_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rcib check failed");

`endif

/* rtl/rcib_pkg.sv */
// ---------------------------------------------------------------------------
// rcib_pkg
// shared constants, types and elaboration-time weight table builder for the blend core
// ---------------------------------------------------------------------------
`default_nettype none

package rcib_pkg;

   localparam int SIDE_MAX    = 4096;
   localparam int ANGLE_STEPS = 1024;

   localparam int CSR_W = 13;
   localparam int POS_W = 12;
   localparam int PIX_W = 8;

   localparam int CEN_W = $clog2(SIDE_MAX);
   localparam int D2_W  = 2 * CEN_W + 1;
   localparam int R2_W  = 2 * CEN_W;
   localparam int Q_W   = $clog2(ANGLE_STEPS);
   localparam int IDX_W = $clog2(ANGLE_STEPS + 1);
   localparam int SH_W  = (Q_W > 1) ? $clog2(Q_W) : 1;
   localparam int TGT_W = D2_W + 2 * Q_W + 1;

   localparam logic CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic CSR_IMAGE_HEIGHT = 1'b1;

   localparam logic [63:0] PI_Q62  = 64'hC90FDAA22168C235;
   localparam logic [63:0] ONE_Q62 = 64'h4000000000000000;

   typedef struct packed {
      logic [PIX_W-1:0] first_blue;
      logic [PIX_W-1:0] first_green;
      logic [PIX_W-1:0] first_red;
      logic [PIX_W-1:0] second_blue;
      logic [PIX_W-1:0] second_green;
      logic [PIX_W-1:0] second_red;
   } pix_type;

   typedef struct packed {
      logic adv_prod;
      logic adv_out;
   } mix_ctl_type;

   typedef logic [PIX_W-1:0] weight_rom_type [0:ANGLE_STEPS];

   function automatic logic [63:0] mul_shr(input logic [63:0] a, input logic [63:0] b,
                                           input int unsigned s);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      p = p >> s;
      return p[63:0];
   endfunction

   function automatic logic [63:0] cos_q62(input logic [63:0] m);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] pos;
      logic [63:0] neg;
      x    = (PI_Q62 / 64'(ANGLE_STEPS)) * m + ((PI_Q62 % 64'(ANGLE_STEPS)) * m)
             / 64'(ANGLE_STEPS);
      x2   = mul_shr(x, x, 62);
      term = ONE_Q62;
      pos  = ONE_Q62;
      neg  = 64'd0;
      for (int k = 1; k <= 14; k++) begin
         term = mul_shr(term, x2, 62) / 64'((2 * k - 1) * (2 * k));
         if (k % 2 == 1) begin
            neg = neg + term;
         end else begin
            pos = pos + term;
         end
      end
      return (pos > neg) ? pos - neg : 64'd0;
   endfunction

   function automatic weight_rom_type build_weights();
      weight_rom_type t;
      logic [63:0]    u;
      logic [63:0]    c;
      logic [63:0]    wq;
      for (int q = 0; q <= ANGLE_STEPS; q++) begin
         if (2 * q <= ANGLE_STEPS) begin
            u = ONE_Q62 + cos_q62(64'(q));
         end else begin
            c = cos_q62(64'(ANGLE_STEPS - q));
            u = (c < ONE_Q62) ? ONE_Q62 - c : 64'd0;
         end
         wq   = mul_shr(64'd255, u, 63);
         t[q] = wq[PIX_W-1:0];
      end
      return t;
   endfunction

   // floor(v/255) for v below 65535
   function automatic logic [PIX_W:0] div255(input logic [2*PIX_W:0] v);
      logic [2*PIX_W:0] s;
      s = v + {{PIX_W{1'b0}}, v[2*PIX_W:PIX_W]} + (2*PIX_W+1)'(1);
      return s[2*PIX_W:PIX_W];
   endfunction

endpackage

`default_nettype wire

/* rtl/rcib_root_step.sv */
// ---------------------------------------------------------------------------
// rcib_root_step
// one bit of the distance ratio, found by a trial square against the target
// ---------------------------------------------------------------------------
`default_nettype none

module rcib_root_step
   import rcib_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              advance,
   input  wire logic [SH_W-1:0]   bit_pos,
   input  wire logic [R2_W-1:0]   radius_sq,
   input  wire logic [Q_W-1:0]    q_in,
   input  wire logic [TGT_W-1:0]  acc_in,
   input  wire logic [D2_W-1:0]   dist_in,
   output logic      [Q_W-1:0]    q_out,
   output logic      [TGT_W-1:0]  acc_out,
   output logic      [D2_W-1:0]   dist_out
);

   logic [Q_W-1:0]   q_ff;
   logic [TGT_W-1:0] acc_ff;
   logic [D2_W-1:0]  dist_ff;
   logic [Q_W:0]     lin;
   logic [2*Q_W:0]   inc;
   logic [TGT_W-1:0] prod;
   logic [TGT_W-1:0] trial;
   logic [TGT_W-1:0] target;
   logic [Q_W-1:0]   q_in_next;
   logic [TGT_W-1:0] acc_in_next;

   // (c^2 - q^2) = (2q + 2^k) * 2^k
   assign lin    = {q_in, 1'b0} + ((Q_W+1)'(1) << bit_pos);
   assign inc    = (2*Q_W+1)'(lin) << bit_pos;
   assign prod   = TGT_W'(inc) * TGT_W'(radius_sq);
   assign trial  = acc_in + prod;
   assign target = TGT_W'(dist_in) << (2 * Q_W);

   always_comb begin
      q_in_next   = q_in;
      acc_in_next = acc_in;
      if (trial <= target) begin
         q_in_next   = q_in | (Q_W'(1) << bit_pos);
         acc_in_next = trial;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         q_ff    <= q_in_next;
         acc_ff  <= acc_in_next;
         dist_ff <= dist_in;
      end
   end

   assign q_out    = q_ff;
   assign acc_out  = acc_ff;
   assign dist_out = dist_ff;

endmodule

`default_nettype wire

/* rtl/rcib_weight_rom.sv */
// ---------------------------------------------------------------------------
// rcib_weight_rom
// raised cosine weight table with registered read
// ---------------------------------------------------------------------------
`default_nettype none

module rcib_weight_rom
   import rcib_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              advance,
   input  wire logic [IDX_W-1:0]  index,
   output logic      [PIX_W-1:0]  weight
);

   localparam weight_rom_type WEIGHT_MEM = build_weights();

   logic [PIX_W-1:0] weight_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         weight_ff <= WEIGHT_MEM[index];
      end
   end

   assign weight = weight_ff;

endmodule

`default_nettype wire

/* rtl/rcib_mix.sv */
// ---------------------------------------------------------------------------
// rcib_mix
// weighted channel products, rounding divide by 255 and saturation
// ---------------------------------------------------------------------------
`default_nettype none

module rcib_mix
   import rcib_pkg::*;
(
   input  wire logic              clock,
   input  wire mix_ctl_type       ctl,
   input  wire logic [PIX_W-1:0]  weight,
   input  wire pix_type           pix,
   output logic      [PIX_W-1:0]  blue,
   output logic      [PIX_W-1:0]  green,
   output logic      [PIX_W-1:0]  red
);

   logic [2*PIX_W-1:0] pa_ff [0:2];
   logic [2*PIX_W-1:0] pb_ff [0:2];
   logic [PIX_W-1:0]   out_ff [0:2];
   logic [PIX_W-1:0]   a_in [0:2];
   logic [PIX_W-1:0]   b_in [0:2];
   logic [PIX_W-1:0]   out_in [0:2];
   logic [PIX_W-1:0]   inv_w;

   assign inv_w = PIX_W'(255) - weight;
   assign a_in[0] = pix.first_blue;
   assign a_in[1] = pix.first_green;
   assign a_in[2] = pix.first_red;
   assign b_in[0] = pix.second_blue;
   assign b_in[1] = pix.second_green;
   assign b_in[2] = pix.second_red;

   always_comb begin
      logic [PIX_W:0]   ha;
      logic [PIX_W:0]   hb;
      logic [PIX_W+1:0] s;
      for (int c = 0; c < 3; c++) begin
         ha = div255({1'b0, pa_ff[c]} + (2*PIX_W+1)'(127));
         hb = div255({1'b0, pb_ff[c]} + (2*PIX_W+1)'(127));
         s  = {1'b0, ha} + {1'b0, hb};
         out_in[c] = (s > (PIX_W+2)'(255)) ? PIX_W'(255) : s[PIX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      for (int c = 0; c < 3; c++) begin
         if (ctl.adv_prod) begin
            pa_ff[c] <= a_in[c] * weight;
            pb_ff[c] <= b_in[c] * inv_w;
         end
         if (ctl.adv_out) begin
            out_ff[c] <= out_in[c];
         end
      end
   end

   assign blue  = out_ff[0];
   assign green = out_ff[1];
   assign red   = out_ff[2];

endmodule

`default_nettype wire

/* rtl/radial_cosine_image_blend_core.sv */
// ---------------------------------------------------------------------------
// radial_cosine_image_blend_core
// blends two pixels with a raised cosine weight of their distance from center
// ---------------------------------------------------------------------------
// Fully pipelined: one pixel pair per clock while the response side is not
// stalled. The stages are input capture, squared distance, ten ratio bits (one
// trial square per stage), the weight table read, the channel products and the
// divide/saturate stage. Each stage holds its own valid bit, so bubbles close
// up and a stalled response holds only as many stages as are full. Image size
// writes take effect once they have passed the size registers and then the
// registered center and squared radius.
`default_nettype none

module radial_cosine_image_blend_core
   import rcib_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_write,
   input  wire logic              csr_index,
   input  wire logic [CSR_W-1:0]  csr_data,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [POS_W-1:0]  req_pos_x,
   input  wire logic [POS_W-1:0]  req_pos_y,
   input  wire logic [PIX_W-1:0]  req_first_blue,
   input  wire logic [PIX_W-1:0]  req_first_green,
   input  wire logic [PIX_W-1:0]  req_first_red,
   input  wire logic [PIX_W-1:0]  req_second_blue,
   input  wire logic [PIX_W-1:0]  req_second_green,
   input  wire logic [PIX_W-1:0]  req_second_red,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic      [PIX_W-1:0]  rsp_out_blue,
   output logic      [PIX_W-1:0]  rsp_out_green,
   output logic      [PIX_W-1:0]  rsp_out_red
);

   localparam int NST   = Q_W + 5;
   localparam int S_D2  = 1;
   localparam int S_ROM = Q_W + 2;
   localparam int S_PRD = Q_W + 3;

   logic [CSR_W-1:0] width_ff;
   logic [CSR_W-1:0] height_ff;
   logic [R2_W-1:0]  r2_ff;
   logic [CEN_W-1:0] cx_ff;
   logic [CEN_W-1:0] cy_ff;
   logic [CSR_W-1:0] wcl;
   logic [CSR_W-1:0] hcl;
   logic [CEN_W-1:0] cx_in;
   logic [CEN_W-1:0] cy_in;
   logic [R2_W-1:0]  cx_sq;
   logic [R2_W-1:0]  cy_sq;
   logic [R2_W-1:0]  r2_in;

   logic [NST-1:0]   valid_ff;
   logic [NST:0]     adv;

   pix_type          pix_ff [0:S_PRD-1];
   logic             zero_ff [S_D2:S_ROM-1];
   logic             far_ff [S_D2:S_ROM-1];
   logic [POS_W-1:0] x_ff;
   logic [POS_W-1:0] y_ff;
   logic [D2_W-1:0]  d2_ff;
   logic [CEN_W-1:0] dx;
   logic [CEN_W-1:0] dy;
   logic [R2_W-1:0]  dx_sq;
   logic [R2_W-1:0]  dy_sq;
   logic [D2_W-1:0]  d2_in;

   logic [Q_W-1:0]   q_pipe [0:Q_W];
   logic [TGT_W-1:0] acc_pipe [0:Q_W];
   logic [D2_W-1:0]  dist_pipe [0:Q_W];
   logic [IDX_W-1:0] rom_idx;
   logic [PIX_W-1:0] weight;
   mix_ctl_type      mix_ctl;

   // image size registers and derived center/radius
   assign wcl   = (width_ff > CSR_W'(SIDE_MAX)) ? CSR_W'(SIDE_MAX) : width_ff;
   assign hcl   = (height_ff > CSR_W'(SIDE_MAX)) ? CSR_W'(SIDE_MAX) : height_ff;
   assign cx_in = wcl[CEN_W:1];
   assign cy_in = hcl[CEN_W:1];
   assign cx_sq = cx_ff * cx_ff;
   assign cy_sq = cy_ff * cy_ff;
   assign r2_in = cx_sq + cy_sq;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= CSR_W'(640);
         height_ff <= CSR_W'(480);
      end else if (csr_write) begin
         case (csr_index)
            CSR_IMAGE_WIDTH: begin
               width_ff <= csr_data;
            end
            CSR_IMAGE_HEIGHT: begin
               height_ff <= csr_data;
            end
            default: begin
            end
         endcase
      end
      cx_ff <= cx_in;
      cy_ff <= cy_in;
      r2_ff <= r2_in;
   end

   // per-stage advance, bubbles collapse
   always_comb begin
      adv[NST] = !rsp_stall;
      for (int i = NST - 1; i >= 0; i--) begin
         adv[i] = !valid_ff[i] || adv[i+1];
      end
   end

   assign req_stall = !adv[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (adv[0]) begin
            valid_ff[0] <= req_valid;
         end
         for (int i = 1; i < NST; i++) begin
            if (adv[i]) begin
               valid_ff[i] <= valid_ff[i-1];
            end
         end
      end
   end

   // input capture
   always_ff @(posedge clock) begin
      if (adv[0]) begin
         x_ff      <= req_pos_x;
         y_ff      <= req_pos_y;
      end
   end

   // squared distance from center
   assign dx    = (cx_ff > x_ff) ? cx_ff - x_ff : x_ff - cx_ff;
   assign dy    = (cy_ff > y_ff) ? cy_ff - y_ff : y_ff - cy_ff;
   assign dx_sq = dx * dx;
   assign dy_sq = dy * dy;
   assign d2_in = D2_W'(dx_sq) + D2_W'(dy_sq);

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         pix_ff[0] <= '{first_blue: req_first_blue, first_green: req_first_green,
                        first_red: req_first_red, second_blue: req_second_blue,
                        second_green: req_second_green, second_red: req_second_red};
      end
      if (adv[S_D2]) begin
         d2_ff          <= d2_in;
         zero_ff[S_D2]  <= (r2_ff == '0);
         far_ff[S_D2]   <= (d2_in >= D2_W'(r2_ff));
         pix_ff[S_D2]   <= pix_ff[0];
      end
      for (int i = S_D2 + 1; i < S_ROM; i++) begin
         if (adv[i]) begin
            zero_ff[i] <= zero_ff[i-1];
            far_ff[i]  <= far_ff[i-1];
         end
      end
      for (int i = S_D2 + 1; i < S_PRD; i++) begin
         if (adv[i]) begin
            pix_ff[i] <= pix_ff[i-1];
         end
      end
   end

   // ratio bits, most significant first
   assign q_pipe[0]    = '0;
   assign acc_pipe[0]  = '0;
   assign dist_pipe[0] = d2_ff;

   for (genvar j = 0; j < Q_W; j++) begin : g_root
      rcib_root_step u_step (
         .clock     (clock),
         .advance   (adv[S_D2+1+j]),
         .bit_pos   (SH_W'(Q_W - 1 - j)),
         .radius_sq (r2_ff),
         .q_in      (q_pipe[j]),
         .acc_in    (acc_pipe[j]),
         .dist_in   (dist_pipe[j]),
         .q_out     (q_pipe[j+1]),
         .acc_out   (acc_pipe[j+1]),
         .dist_out  (dist_pipe[j+1])
      );
   end

   always_comb begin
      if (zero_ff[S_ROM-1]) begin
         rom_idx = '0;
      end else if (far_ff[S_ROM-1]) begin
         rom_idx = IDX_W'(ANGLE_STEPS);
      end else begin
         rom_idx = IDX_W'(q_pipe[Q_W]);
      end
   end

   rcib_weight_rom u_rom (
      .clock   (clock),
      .advance (adv[S_ROM]),
      .index   (rom_idx),
      .weight  (weight)
   );

   assign mix_ctl = '{adv_prod: adv[S_PRD], adv_out: adv[S_PRD+1]};

   rcib_mix u_mix (
      .clock  (clock),
      .ctl    (mix_ctl),
      .weight (weight),
      .pix    (pix_ff[S_PRD-1]),
      .blue   (rsp_out_blue),
      .green  (rsp_out_green),
      .red    (rsp_out_red)
   );

   assign rsp_valid = valid_ff[NST-1];

   `include "radial_cosine_image_blend_core_assert.svh"

   `RCIB_ASSERT_NOW(a_stall_only_when_full, clock, reset, req_stall, rsp_valid && rsp_stall && (&valid_ff))
   `RCIB_ASSERT_NEXT(a_beat_reaches_out, clock, reset, valid_ff[NST-2] && adv[NST-1], rsp_valid)
   `RCIB_ASSERT_NEXT(a_held_under_stall, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_out_blue))

endmodule

`default_nettype wire

/* test/tb_radial_cosine_image_blend_core.sv */
// ---------------------------------------------------------------------------
// tb_radial_cosine_image_blend_core
// self-checking bench for the radial cosine blend core
// ---------------------------------------------------------------------------
// Pixel pairs are sent in random bursts under several image sizes, small,
// large, clamped and degenerate. An in-bench model computes the cosine weight
// table and each blended pixel, and a monitor compares every response beat
// in order against the queued predictions while the response side stalls on
// its own pattern.
`default_nettype none

module tb_radial_cosine_image_blend_core;
   import rcib_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 5000;

   typedef struct packed {
      logic [PIX_W-1:0] blue;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] red;
   } bgr_type;

   logic              clock;
   logic              reset;
   logic              csr_write;
   logic              csr_index;
   logic [CSR_W-1:0]  csr_data;
   logic              req_valid;
   logic              req_stall;
   logic [POS_W-1:0]  req_pos_x;
   logic [POS_W-1:0]  req_pos_y;
   logic [PIX_W-1:0]  req_first_blue;
   logic [PIX_W-1:0]  req_first_green;
   logic [PIX_W-1:0]  req_first_red;
   logic [PIX_W-1:0]  req_second_blue;
   logic [PIX_W-1:0]  req_second_green;
   logic [PIX_W-1:0]  req_second_red;
   logic              rsp_valid;
   logic              rsp_stall;
   logic [PIX_W-1:0]  rsp_out_blue;
   logic [PIX_W-1:0]  rsp_out_green;
   logic [PIX_W-1:0]  rsp_out_red;

   radial_cosine_image_blend_core u_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .req_first_blue   (req_first_blue),
      .req_first_green  (req_first_green),
      .req_first_red    (req_first_red),
      .req_second_blue  (req_second_blue),
      .req_second_green (req_second_green),
      .req_second_red   (req_second_red),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_blue     (rsp_out_blue),
      .rsp_out_green    (rsp_out_green),
      .rsp_out_red      (rsp_out_red)
   );

   bgr_type     blend_queue[$];
   logic [7:0]  mask_weight [0:ANGLE_STEPS];
   int unsigned model_width;
   int unsigned model_height;
   int          error_count;
   int          idle_cycles;
   int          burst_left;
   bit          gaps_enabled;
   int          stall_mode;
   int          stall_timer;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // (a*b) >> s with a full-width product
   function automatic logic [63:0] scaled_product(input logic [63:0] a, input logic [63:0] b,
                                                  input int s);
      logic [127:0] wide;
      wide = ({64'd0, a} * {64'd0, b}) >> s;
      return wide[63:0];
   endfunction

   function automatic logic [63:0] cosine_fixed(input logic [63:0] step);
      logic [63:0] angle;
      logic [63:0] angle_sq;
      logic [63:0] term;
      logic [63:0] plus_sum;
      logic [63:0] minus_sum;
      angle = (PI_Q62 / ANGLE_STEPS) * step + ((PI_Q62 % ANGLE_STEPS) * step) / ANGLE_STEPS;
      angle_sq  = scaled_product(angle, angle, 62);
      term      = ONE_Q62;
      plus_sum  = ONE_Q62;
      minus_sum = 64'd0;
      for (int k = 1; k <= 14; k++) begin
         term = scaled_product(term, angle_sq, 62) / 64'((2 * k - 1) * (2 * k));
         if (k % 2 == 1) begin
            minus_sum += term;
         end else begin
            plus_sum += term;
         end
      end
      return (plus_sum > minus_sum) ? plus_sum - minus_sum : 64'd0;
   endfunction

   function automatic int unsigned radial_step(input int unsigned x, input int unsigned y);
      longint unsigned w, h, cx, cy, dx, dy, d2, r2, goal, lo, hi, mid;
      w  = (model_width > SIDE_MAX) ? SIDE_MAX : model_width;
      h  = (model_height > SIDE_MAX) ? SIDE_MAX : model_height;
      cx = w / 2;
      cy = h / 2;
      dx = (cx > x) ? cx - x : x - cx;
      dy = (cy > y) ? cy - y : y - cy;
      d2 = dx * dx + dy * dy;
      r2 = cx * cx + cy * cy;
      if (r2 == 0) return 0;
      if (d2 >= r2) return ANGLE_STEPS;
      goal = longint'(ANGLE_STEPS) * ANGLE_STEPS * d2;
      lo   = 0;
      hi   = ANGLE_STEPS - 1;
      while (lo < hi) begin
         mid = (lo + hi + 1) / 2;
         if (mid * mid * r2 <= goal) lo = mid;
         else hi = mid - 1;
      end
      return int'(lo);
   endfunction

   function automatic logic [7:0] mix_channel(input int a, input int b, input int w);
      int s;
      s = (a * w + 127) / 255 + (b * (255 - w) + 127) / 255;
      return (s > 255) ? 8'd255 : 8'(s);
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch on %s: got %0d expected %0d", what, got, want);
      error_count++;
   endtask

   // response monitor and stall pattern
   always @(posedge clock) begin
      bgr_type want;
      if (reset) begin
         rsp_stall   <= 1'b0;
         stall_timer <= 0;
         stall_mode  <= 0;
      end else begin
         if (stall_timer == 0) begin
            stall_mode  <= $urandom_range(0, 3);
            stall_timer <= $urandom_range(20, 300);
         end else begin
            stall_timer <= stall_timer - 1;
         end
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 9) == 0);
            2: rsp_stall <= ($urandom_range(0, 1) == 0);
            default: rsp_stall <= ($urandom_range(0, 9) < 8);
         endcase
         if (rsp_valid && !rsp_stall) begin
            if (blend_queue.size() == 0) begin
               $display("response beat with no pixel outstanding");
               error_count++;
            end else begin
               want = blend_queue.pop_front();
               if (rsp_out_blue !== want.blue) report_mismatch("blue", rsp_out_blue, want.blue);
               if (rsp_out_green !== want.green)
                  report_mismatch("green", rsp_out_green, want.green);
               if (rsp_out_red !== want.red) report_mismatch("red", rsp_out_red, want.red);
            end
         end
      end
   end

   // watchdog on lack of progress
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired with %0d pixels outstanding", blend_queue.size());
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   task automatic send_pixel(input int x, input int y, input logic [7:0] fb, input logic [7:0] fg,
                             input logic [7:0] fr, input logic [7:0] sb, input logic [7:0] sg,
                             input logic [7:0] sr);
      int      w;
      bgr_type want;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         if (gaps_enabled) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, ($urandom_range(0, 4) == 0) ? 30 : 4)) @(posedge clock);
         end
      end
      burst_left--;
      req_valid        <= 1'b1;
      req_pos_x        <= POS_W'(x);
      req_pos_y        <= POS_W'(y);
      req_first_blue   <= fb;
      req_first_green  <= fg;
      req_first_red    <= fr;
      req_second_blue  <= sb;
      req_second_green <= sg;
      req_second_red   <= sr;
      do @(posedge clock); while (req_stall);
      w          = mask_weight[radial_step(x % 4096, y % 4096)];
      want.blue  = mix_channel(fb, sb, w);
      want.green = mix_channel(fg, sg, w);
      want.red   = mix_channel(fr, sr, w);
      blend_queue.push_back(want);
   endtask

   task automatic drain_pixels();
      req_valid <= 1'b0;
      @(posedge clock);
      while (blend_queue.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic set_image_size(input int unsigned w, input int unsigned h);
      drain_pixels();
      csr_write <= 1'b1;
      csr_index <= CSR_IMAGE_WIDTH;
      csr_data  <= CSR_W'(w);
      @(posedge clock);
      csr_index <= CSR_IMAGE_HEIGHT;
      csr_data  <= CSR_W'(h);
      @(posedge clock);
      csr_write <= 1'b0;
      repeat (4) @(posedge clock);
      model_width  = w;
      model_height = h;
   endtask

   function automatic logic [7:0] random_channel();
      case ($urandom_range(0, 5))
         0: return 8'd0;
         1: return 8'd255;
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic send_random_pixels(input int count);
      int w, h, x, y;
      w = (model_width > SIDE_MAX) ? SIDE_MAX : model_width;
      h = (model_height > SIDE_MAX) ? SIDE_MAX : model_height;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 4) == 0 || w == 0 || h == 0) begin
            x = $urandom_range(0, 4095);
            y = $urandom_range(0, 4095);
         end else begin
            x = $urandom_range(0, w - 1);
            y = $urandom_range(0, h - 1);
         end
         send_pixel(x, y, random_channel(), random_channel(), random_channel(),
                    random_channel(), random_channel(), random_channel());
      end
   endtask

   // reset size: corners, center, edges, out of frame, channel extremes
   task automatic test_directed_default();
      gaps_enabled = 1'b0;
      send_pixel(320, 240, 255, 255, 255, 0, 0, 0);
      send_pixel(320, 240, 0, 0, 0, 255, 255, 255);
      send_pixel(0, 0, 255, 255, 255, 0, 0, 0);
      send_pixel(0, 0, 0, 0, 0, 255, 255, 255);
      send_pixel(639, 479, 255, 128, 1, 254, 127, 0);
      send_pixel(639, 0, 200, 100, 50, 10, 20, 30);
      send_pixel(0, 479, 255, 255, 255, 255, 255, 255);
      send_pixel(4095, 4095, 17, 34, 51, 255, 255, 255);
      send_pixel(4095, 0, 255, 0, 255, 0, 255, 0);
      send_pixel(160, 120, 254, 255, 253, 255, 254, 255);
      send_pixel(480, 360, 255, 254, 255, 254, 255, 254);
      send_pixel(100, 240, 170, 85, 240, 15, 170, 85);
      send_pixel(320, 0, 1, 2, 3, 252, 253, 254);
      drain_pixels();
   endtask

   // zero and one sized images give a zero radius
   task automatic test_zero_radius();
      set_image_size(0, 0);
      send_pixel(0, 0, 255, 255, 255, 0, 0, 0);
      send_pixel(4095, 4095, 10, 20, 30, 200, 210, 220);
      set_image_size(1, 1);
      send_pixel(0, 0, 0, 128, 255, 255, 128, 0);
      send_random_pixels(20);
   endtask

   // registers above the side limit clamp to it
   task automatic test_largest_sizes();
      set_image_size(8191, 8191);
      send_pixel(2048, 2048, 255, 255, 255, 0, 0, 0);
      send_pixel(0, 0, 255, 255, 255, 0, 0, 0);
      send_pixel(4095, 4095, 99, 199, 9, 250, 5, 128);
      send_random_pixels(40);
      set_image_size(4096, 4096);
      send_random_pixels(40);
   endtask

   task automatic test_random_sizes();
      int unsigned sizes[10][2] = '{'{640, 480}, '{7, 3}, '{1, 4096}, '{13, 1}, '{2, 2},
                                    '{4096, 17}, '{5000, 300}, '{64, 64}, '{0, 31}, '{33, 0}};
      for (int p = 0; p < 10; p++) begin
         set_image_size(sizes[p][0], sizes[p][1]);
         gaps_enabled = (p % 3 != 0);
         send_random_pixels(100);
      end
      for (int p = 0; p < 4; p++) begin
         set_image_size($urandom_range(1, 8191), $urandom_range(1, 8191));
         gaps_enabled = 1'b1;
         send_random_pixels(75);
      end
   endtask

   initial begin
      logic [63:0] unit;
      logic [63:0] c;
      for (int q = 0; q <= ANGLE_STEPS; q++) begin
         if (2 * q <= ANGLE_STEPS) begin
            unit = ONE_Q62 + cosine_fixed(64'(q));
         end else begin
            c    = cosine_fixed(64'(ANGLE_STEPS - q));
            unit = (c < ONE_Q62) ? ONE_Q62 - c : 64'd0;
         end
         mask_weight[q] = 8'(scaled_product(64'd255, unit, 63));
      end
      model_width      = 640;
      model_height     = 480;
      error_count      = 0;
      burst_left       = 0;
      gaps_enabled     = 1'b1;
      reset            = 1'b1;
      csr_write        = 1'b0;
      csr_index        = CSR_IMAGE_WIDTH;
      csr_data         = '0;
      req_valid        = 1'b0;
      req_pos_x        = '0;
      req_pos_y        = '0;
      req_first_blue   = '0;
      req_first_green  = '0;
      req_first_red    = '0;
      req_second_blue  = '0;
      req_second_green = '0;
      req_second_red   = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_default();
      test_zero_radius();
      test_largest_sizes();
      test_random_sizes();
      drain_pixels();
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

`default_nettype wire

/* radial_cosine_image_blend_core.f */
+incdir+rtl
rtl/rcib_pkg.sv
rtl/rcib_root_step.sv
rtl/rcib_weight_rom.sv
rtl/rcib_mix.sv
rtl/radial_cosine_image_blend_core.sv
test/tb_radial_cosine_image_blend_core.sv
